// ----- hw/rtl/b32se_pkg.sv -----
// Shared types, constants and helper functions for the base32 stream encoder.
`timescale 1ns / 1ps
`default_nettype none

package b32se_pkg;

   localparam int unsigned DATA_W          = 8;
   localparam int unsigned CHAR_W          = 7;
   localparam int unsigned SYM_W           = 5;
   localparam int unsigned CARRY_W         = 4;
   localparam int unsigned PHASE_W         = 3;
   localparam int unsigned LIMIT_W         = 16;
   localparam int unsigned USED_W          = 16;
   localparam int unsigned MAX_RES         = 3;
   localparam int unsigned RES_CNT_W       = 2;
   localparam int unsigned RSP_DATA_W      = 24;
   localparam int unsigned COUNT_WIDTH_DEF = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

   localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd4;

   // Alphabet: 0..25 -> 'A'..'Z', 26..31 -> '2'..'7'
   localparam logic [CHAR_W-1:0] ASCII_A         = 7'd65;
   localparam logic [CHAR_W-1:0] ASCII_DIGIT_OFS = 7'd24;
   localparam logic [SYM_W-1:0]  SYM_FIRST_DIGIT = 5'd26;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [CARRY_W-1:0] carry;
      logic               halted;
   } ctl_type;

   // Results caused by one request, delivered one per cycle while the receiver is ready.
   typedef struct packed {
      logic [MAX_RES-1:0][CHAR_W-1:0] code;
      logic [RES_CNT_W-1:0]           count;
      logic                           status_only;
      logic                           msg_end;
      logic [USED_W-1:0]              bytes_used;
   } bundle_type;

   function automatic logic [CHAR_W-1:0] sym_to_ascii(input logic [SYM_W-1:0] s);
      logic [CHAR_W-1:0] base;
      base = (s < SYM_FIRST_DIGIT) ? ASCII_A : ASCII_DIGIT_OFS;
      return CHAR_W'(s) + base;
   endfunction

   // Character that straddles the previous byte's carry and byte b.
   function automatic logic [SYM_W-1:0] span_char(input logic [PHASE_W-1:0] q,
                                                 input logic [CARRY_W-1:0] carry,
                                                 input logic [DATA_W-1:0]  b);
      logic [SYM_W-1:0] s;
      case (q)
         3'd1:    s = {carry[2:0], b[7:6]};
         3'd2:    s = {carry[0],   b[7:4]};
         3'd3:    s = {carry[3:0], b[7]};
         default: s = {carry[1:0], b[7:5]};
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/b32se_enc.sv -----
// Single-pass encode of one byte: next state and the results it produces.
`timescale 1ns / 1ps
`default_nettype none

module b32se_enc #(
   parameter int unsigned COUNT_WIDTH = b32se_pkg::COUNT_WIDTH_DEF
) (
   input  wire b32se_pkg::ctl_type                ctl,
   input  wire logic [COUNT_WIDTH-1:0]            chars,
   input  wire logic [COUNT_WIDTH-1:0]            bytes,
   input  wire logic [b32se_pkg::LIMIT_W-1:0]     limit,
   input  wire logic [b32se_pkg::DATA_W-1:0]      data_byte,
   input  wire logic                              last_byte,
   output b32se_pkg::ctl_type                     ctl_next,
   output logic [COUNT_WIDTH-1:0]                 chars_next,
   output logic [COUNT_WIDTH-1:0]                 bytes_next,
   output logic                                   has_result,
   output b32se_pkg::bundle_type                  bundle
);

   localparam int unsigned LW = ((COUNT_WIDTH > b32se_pkg::LIMIT_W) ?
                                 COUNT_WIDTH : b32se_pkg::LIMIT_W) + 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [LW-1:0]                       limit_ext;
   logic [LW-1:0]                       cmax_ext;
   logic [LW-1:0]                       lim;
   logic [LW-1:0]                       sum;
   logic [LW-1:0]                       used_ext;
   logic [1:0]                          need;
   logic                                fits;
   logic [b32se_pkg::PHASE_W-1:0]       p;
   logic [b32se_pkg::RES_CNT_W-1:0]     n;
   logic [b32se_pkg::SYM_W-1:0]         own;
   logic                                own_valid;

   assign p         = ctl.phase;
   assign need      = (p == 3'd2 || p == b32se_pkg::PHASE_LAST) ? 2'd1 : 2'd2;
   assign limit_ext = LW'(limit);
   assign cmax_ext  = LW'(COUNT_MAX);
   assign lim       = (limit_ext < cmax_ext) ? limit_ext : cmax_ext;
   assign sum       = LW'(chars) + LW'(need);
   assign fits      = (sum <= lim);

   always_comb begin
      case (p)
         3'd0:    own = data_byte[7:3];
         3'd1:    own = data_byte[5:1];
         3'd3:    own = data_byte[6:2];
         default: own = data_byte[4:0];
      endcase
      own_valid = (p != 3'd2);
   end

   always_comb begin
      ctl_next   = ctl;
      chars_next = chars;
      bytes_next = bytes;
      n          = '0;
      bundle     = '0;
      used_ext   = '0;

      if (!ctl.halted) begin
         if (p != 3'd0) begin
            bundle.code[n] = b32se_pkg::sym_to_ascii(b32se_pkg::span_char(p, ctl.carry,
                                                                         data_byte));
            n = n + 2'd1;
         end
         if (fits) begin
            chars_next = COUNT_WIDTH'(sum);
            if (bytes != COUNT_MAX) begin
               bytes_next = bytes + COUNT_WIDTH'(1);
            end
            if (own_valid) begin
               bundle.code[n] = b32se_pkg::sym_to_ascii(own);
               n = n + 2'd1;
            end
            case (p)
               3'd0:    ctl_next.carry = {1'b0, data_byte[2:0]};
               3'd1:    ctl_next.carry = {3'b000, data_byte[0]};
               3'd2:    ctl_next.carry = data_byte[3:0];
               3'd3:    ctl_next.carry = {2'b00, data_byte[1:0]};
               default: ctl_next.carry = '0;
            endcase
            ctl_next.phase = (p == b32se_pkg::PHASE_LAST) ? 3'd0 : p + 3'd1;
            // last byte: flush the pending straddling character with zero fill
            if (last_byte && p != b32se_pkg::PHASE_LAST) begin
               bundle.code[n] = b32se_pkg::sym_to_ascii(
                  b32se_pkg::span_char(p + 3'd1, ctl_next.carry, '0));
               n = n + 2'd1;
            end
         end else begin
            ctl_next.halted = 1'b1;
            ctl_next.phase  = '0;
            ctl_next.carry  = '0;
         end
      end

      bundle.count = n;
      if (last_byte) begin
         used_ext           = LW'(bytes_next);
         bundle.msg_end     = 1'b1;
         bundle.bytes_used  = used_ext[b32se_pkg::USED_W-1:0];
         if (n == '0) begin
            bundle.status_only = 1'b1;
            bundle.count       = 2'd1;
         end
         ctl_next   = '0;
         chars_next = '0;
         bytes_next = '0;
      end
      has_result = (bundle.count != '0);
   end

endmodule

`default_nettype wire

// ----- hw/rtl/base32_stream_encoder_top.sv -----
// Top level of the unpadded base32 stream encoder.
//
// Request channel (req_*): one message byte per request, req_tlast on the
// final byte of a message. Response channel (rsp_*): one base32 character
// (or one status-only item) per response. rsp_tlast marks the final response
// of a message, which carries the count of bytes encoded. csr_wr_en writes
// the output character limit (reset 65535); the user must do so only while the block is idle (not enforced).
//
// A request is registered in the input register, encoded in one pass into a
// result bundle, and the bundle is registered before its first response is on
// the port. A byte yielding two or three characters holds the bundle while
// they leave, since the response port moves one character per cycle while
// rsp_tready is high. Bytes producing nothing pass without the bundle register.
// A stalled receiver holds the current response; one request still enters
// the input register and, if it yields a response, waits there.
// Reset clears the group position, counters, halt flag and all valid flags,
// and restores the limit to 65535.
`timescale 1ns / 1ps
`default_nettype none

module base32_stream_encoder_top #(
   parameter int unsigned COUNT_WIDTH = b32se_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [b32se_pkg::DATA_W-1:0]         req_tdata,   // [7:0] data_byte
   input  wire logic                                 req_tlast,   // last_byte
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [b32se_pkg::RSP_DATA_W-1:0]          rsp_tdata,   // [6:0] char_code,
                                                                  // [7] run_last,
                                                                  // [23:8] bytes_used
   output logic                                      rsp_tuser,   // char_valid
   output logic                                      rsp_tlast,   // message_end
   input  wire logic                                 csr_wr_en,
   input  wire logic [b32se_pkg::LIMIT_W-1:0]        csr_wr_data
);

   logic [b32se_pkg::LIMIT_W-1:0]   limit_ff;
   logic                            in_valid_ff;
   logic [b32se_pkg::DATA_W-1:0]    in_byte_ff;
   logic                            in_last_ff;
   b32se_pkg::ctl_type              ctl_ff;
   logic [COUNT_WIDTH-1:0]          chars_ff;
   logic [COUNT_WIDTH-1:0]          bytes_ff;
   logic                            out_valid_ff;
   b32se_pkg::bundle_type           bundle_ff;
   logic [b32se_pkg::RES_CNT_W-1:0] idx_ff;

   b32se_pkg::ctl_type              ctl_in;
   logic [COUNT_WIDTH-1:0]          chars_in;
   logic [COUNT_WIDTH-1:0]          bytes_in;
   logic                            has_result;
   b32se_pkg::bundle_type           bundle_in;

   logic                            run_last;
   logic                            out_done;
   logic                            bundle_free;
   logic                            advance;
   logic                            req_take;
   logic [b32se_pkg::CHAR_W-1:0]    char_code;

   b32se_enc #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_enc (
      .ctl        (ctl_ff),
      .chars      (chars_ff),
      .bytes      (bytes_ff),
      .limit      (limit_ff),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .ctl_next   (ctl_in),
      .chars_next (chars_in),
      .bytes_next (bytes_in),
      .has_result (has_result),
      .bundle     (bundle_in)
   );

   assign run_last    = (idx_ff == bundle_ff.count - 2'd1);
   assign out_done    = out_valid_ff && rsp_tready && run_last;
   assign bundle_free = !out_valid_ff || out_done;
   // an encoded byte with no response does not need the bundle register
   assign advance     = in_valid_ff && (!has_result || bundle_free);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= b32se_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff   <= '0;
         chars_ff <= '0;
         bytes_ff <= '0;
      end else if (advance) begin
         ctl_ff   <= ctl_in;
         chars_ff <= chars_in;
         bytes_ff <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (advance && has_result) begin
         out_valid_ff <= 1'b1;
         idx_ff       <= '0;
      end else if (out_done) begin
         out_valid_ff <= 1'b0;
      end else if (out_valid_ff && rsp_tready) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         bundle_ff <= bundle_in;
      end
   end

   assign char_code  = bundle_ff.status_only ? '0 : bundle_ff.code[idx_ff];
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = !bundle_ff.status_only;
   assign rsp_tlast  = run_last && bundle_ff.msg_end;
   assign rsp_tdata  = {(rsp_tlast ? bundle_ff.bytes_used : '0), run_last, char_code};

   // index never runs past the bundle's result count
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (bundle_ff.count != '0) && (idx_ff < bundle_ff.count))
      else $error("response index outside bundle");

   // a status-only bundle is exactly one response
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && bundle_ff.status_only) |-> (bundle_ff.count == 2'd1))
      else $error("status-only bundle with several responses");

   // group position stays within a 5-byte group
   assert property (@(posedge clock) disable iff (reset)
      ctl_ff.phase <= b32se_pkg::PHASE_LAST)
      else $error("group phase out of range");

   // end of message clears encoder state
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (ctl_ff == '0) && (chars_ff == '0) && (bytes_ff == '0))
      else $error("state not cleared after message end");

   // a new bundle loads only when the previous one is fully taken
   assert property (@(posedge clock) disable iff (reset)
      (advance && has_result && out_valid_ff) |-> out_done)
      else $error("bundle overwritten before delivery");

endmodule

`default_nettype wire
